@@ hdl/dtc_pkg.sv @@
// Shared widths, constants, types and helper functions of the timestamp splitter.
package dtc_pkg;

    // Pipeline depth: registers from the input beat to the output register.
    localparam int NUM_STAGES  = 10;
    localparam int FRONT_STAGES = 3;
    localparam int TAIL_STAGES = NUM_STAGES - FRONT_STAGES;

    // Port widths.
    localparam int FUNC_W   = 2;
    localparam int DAYS_W   = 23;
    localparam int TVAL_W   = 25;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int MDAY_W   = 5;
    localparam int YDAY_W   = 9;
    localparam int WDAY_W   = 3;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;

    // Internal widths.
    localparam int SECS_W   = 31;
    localparam int QD_W     = 15;
    localparam int SOD_W    = 17;
    localparam int ZZ_W     = 24;
    localparam int ERA_W    = 6;
    localparam int DOE_W    = 18;
    localparam int YOE_W    = 9;
    localparam int MP_W     = 4;
    localparam int REMH_W   = 12;

    // Type selector codes.
    localparam logic [FUNC_W-1:0] FUNC_TICKS   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MINUTES = 2'd1;

    // Calendar constants.
    localparam logic [SOD_W-1:0]  SEC_PER_DAY  = 17'd86400;
    localparam logic [DOE_W-1:0]  ERA_DAYS     = 18'd146097;
    // Shift to make the day count non-negative: 1970 offset, civil epoch
    // offset and 25 whole eras, less the 1900 to 1970 distance.
    localparam logic [24:0]       ZZ_OFFSET    = 25'd4346326;
    localparam logic [YEAR_W-1:0] ERA_BIAS_YEARS = 14'd10000;

    // Reciprocals for division by constants: q = (x * RECIP) >> SHIFT.
    localparam logic [23:0] RECIP_75    = 24'd14316558;
    localparam int          SHIFT_75    = 30;
    localparam logic [24:0] RECIP_675   = 25'd25451659;
    localparam int          SHIFT_675   = 34;
    localparam logic [24:0] RECIP_ERA   = 25'd30103606;
    localparam int          SHIFT_ERA   = 42;
    localparam logic [13:0] RECIP_225   = 14'd9321;
    localparam int          SHIFT_225   = 21;
    localparam logic [10:0] RECIP_15    = 11'd1093;
    localparam int          SHIFT_15    = 14;
    localparam logic [16:0] RECIP_365S  = 17'd91930;
    localparam int          SHIFT_365S  = 25;
    localparam logic [18:0] RECIP_365   = 19'd367720;
    localparam int          SHIFT_365   = 27;
    localparam logic [11:0] RECIP_153   = 12'd3427;
    localparam int          SHIFT_153   = 19;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } hms_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [MDAY_W-1:0]  month_day;
        logic [YDAY_W-1:0]  year_day;
        logic [WDAY_W-1:0]  week_day;
    } date_t;

    // First day of each month within a year that starts on March 1.
    function automatic logic [YDAY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [YDAY_W-1:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Remainder by seven: octal digits sum to the same residue since 8 is 1 mod 7.
    function automatic logic [WDAY_W-1:0] mod7(input logic [ZZ_W-1:0] a);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] r;
        s1 = '0;
        for (int i = 0; i < ZZ_W / 3; i++) begin
            s1 = s1 + 6'(a[3*i +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        if (s2 >= 4'd14) begin
            r = s2 - 4'd14;
        end else if (s2 >= 4'd7) begin
            r = s2 - 4'd7;
        end else begin
            r = s2;
        end
        return r[WDAY_W-1:0];
    endfunction

endpackage

@@ hdl/dtc_ctrl.sv @@
// Valid bits and stall control for the stages of the timestamp pipeline.
module dtc_ctrl
    import dtc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [NUM_STAGES-1:0] stage_en
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;

    // A stage may load when it is empty or when the stage after it loads too.
    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (stage_en[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

`ifndef NO_ASSERTIONS
    // When the output side can move, every stage can move and input is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("pipeline stalled while the output side is free");
`endif

endmodule

@@ hdl/dtc_front.sv @@
// First three stages: seconds from the time part, whole days carried, day number.
module dtc_front
    import dtc_pkg::*;
(
    input  logic                     aclk,
    input  logic [FRONT_STAGES-1:0]  stage_en,
    input  logic [FUNC_W-1:0]        s_func,
    input  logic signed [DAYS_W-1:0] s_day_count,
    input  logic [TVAL_W-1:0]        s_time_value,
    output logic [SOD_W-1:0]         sod,
    output logic [ZZ_W-1:0]          zz
);

    logic [46:0]              prod75;
    logic [SECS_W-1:0]        mins_secs;
    logic [SECS_W-1:0]        secs_next;
    logic [SECS_W-1:0]        secs1_reg;
    logic signed [DAYS_W-1:0] days1_reg;

    logic [48:0]              prod675;
    logic [QD_W-1:0]          qd_next;
    logic [SECS_W-1:0]        secs2_reg;
    logic signed [DAYS_W-1:0] days2_reg;
    logic [QD_W-1:0]          qd2_reg;

    logic [SECS_W-1:0]        sod_wide;
    logic [24:0]              zz_wide;
    logic [SOD_W-1:0]         sod_reg;
    logic [ZZ_W-1:0]          zz_reg;

    // Ticks to seconds: divide by 4, then by 75 through a reciprocal.
    assign prod75    = 47'(s_time_value[TVAL_W-1:2]) * 47'(RECIP_75);
    assign mins_secs = (SECS_W'(s_time_value) << 6) - (SECS_W'(s_time_value) << 2);
    assign secs_next = (s_func == FUNC_MINUTES) ? mins_secs
                                                : SECS_W'(prod75[46:SHIFT_75]);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            secs1_reg <= secs_next;
            days1_reg <= s_day_count;
        end
    end

    // Whole days in the time part: divide by 128, then by 675.
    assign prod675 = 49'(secs1_reg[SECS_W-1:7]) * 49'(RECIP_675);
    assign qd_next = prod675[SHIFT_675 +: QD_W];

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            secs2_reg <= secs1_reg;
            days2_reg <= days1_reg;
            qd2_reg   <= qd_next;
        end
    end

    assign sod_wide = secs2_reg - SECS_W'(qd2_reg) * SECS_W'(SEC_PER_DAY);
    assign zz_wide  = {{2{days2_reg[DAYS_W-1]}}, days2_reg} + 25'(qd2_reg) + ZZ_OFFSET;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            sod_reg <= sod_wide[SOD_W-1:0];
            zz_reg  <= zz_wide[ZZ_W-1:0];
        end
    end

    assign sod = sod_reg;
    assign zz  = zz_reg;

endmodule

@@ hdl/dtc_tod.sv @@
// Time-of-day stages: hour, minute and second from the seconds within the day.
module dtc_tod
    import dtc_pkg::*;
(
    input  logic                   aclk,
    input  logic [TAIL_STAGES-1:0] stage_en,
    input  logic [SOD_W-1:0]       sod,
    output hms_t                   hms
);

    logic [26:0]         prod_hour;
    logic [SOD_W-1:0]    sod4_reg;
    logic [HOUR_W-1:0]   hour4_reg;

    logic [SOD_W-1:0]    remh_wide;
    logic [HOUR_W-1:0]   hour5_reg;
    logic [REMH_W-1:0]   remh5_reg;

    logic [20:0]         prod_min;
    logic [HOUR_W-1:0]   hour6_reg;
    logic [REMH_W-1:0]   remh6_reg;
    logic [MIN_W-1:0]    min6_reg;

    logic [REMH_W-1:0]   sec_wide;
    hms_t                hms_next;
    hms_t                hms_reg [4];

    // Hour: divide by 16, then by 225.
    assign prod_hour = 27'(sod[SOD_W-1:4]) * 27'(RECIP_225);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            sod4_reg  <= sod;
            hour4_reg <= prod_hour[SHIFT_225 +: HOUR_W];
        end
    end

    assign remh_wide = sod4_reg - SOD_W'(hour4_reg) * SOD_W'(3600);

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            hour5_reg <= hour4_reg;
            remh5_reg <= remh_wide[REMH_W-1:0];
        end
    end

    // Minute: divide by 4, then by 15.
    assign prod_min = 21'(remh5_reg[REMH_W-1:2]) * 21'(RECIP_15);

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            hour6_reg <= hour5_reg;
            remh6_reg <= remh5_reg;
            min6_reg  <= prod_min[SHIFT_15 +: MIN_W];
        end
    end

    assign sec_wide = remh6_reg - REMH_W'(min6_reg) * REMH_W'(60);

    always_comb begin
        hms_next.hour   = hour6_reg;
        hms_next.minute = min6_reg;
        hms_next.second = sec_wide[SEC_W-1:0];
    end

    // Finished fields wait here until the date side catches up.
    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            hms_reg[0] <= hms_next;
        end
        for (int k = 1; k < 4; k++) begin
            if (stage_en[3+k]) begin
                hms_reg[k] <= hms_reg[k-1];
            end
        end
    end

    assign hms = hms_reg[3];

endmodule

@@ hdl/dtc_date.sv @@
// Date stages: weekday, 400-year era, year of era, day of year, month and day.
module dtc_date
    import dtc_pkg::*;
(
    input  logic                   aclk,
    input  logic [TAIL_STAGES-1:0] stage_en,
    input  logic [ZZ_W-1:0]        zz,
    output date_t                  date
);

    logic [48:0]         prod_era;
    logic [ZZ_W-1:0]     zz4_reg;
    logic [ERA_W-1:0]    q4_reg;
    logic [WDAY_W-1:0]   wd4_reg;

    logic [ZZ_W-1:0]     doe_wide;
    logic [ERA_W-1:0]    q5_reg;
    logic [DOE_W-1:0]    doe5_reg;
    logic [WDAY_W-1:0]   wd5_reg;

    logic [32:0]         prod_1460;
    logic [DOE_W-1:0]    c36524;
    logic [DOE_W-1:0]    t_next;
    logic [ERA_W-1:0]    q6_reg;
    logic [DOE_W-1:0]    doe6_reg;
    logic [DOE_W-1:0]    t6_reg;
    logic [WDAY_W-1:0]   wd6_reg;

    logic [36:0]         prod_yoe;
    logic [ERA_W-1:0]    q7_reg;
    logic [DOE_W-1:0]    doe7_reg;
    logic [YOE_W-1:0]    yoe7_reg;
    logic [WDAY_W-1:0]   wd7_reg;

    logic [DOE_W-1:0]    c100;
    logic [DOE_W-1:0]    doy_wide;
    logic                leap_next;
    logic [ERA_W-1:0]    q8_reg;
    logic [YOE_W-1:0]    yoe8_reg;
    logic [YDAY_W-1:0]   doy8_reg;
    logic                leap8_reg;
    logic [WDAY_W-1:0]   wd8_reg;

    logic [10:0]         doy_scaled;
    logic [22:0]         prod_mp;
    logic [ERA_W-1:0]    q9_reg;
    logic [YOE_W-1:0]    yoe9_reg;
    logic [YDAY_W-1:0]   doy9_reg;
    logic                leap9_reg;
    logic [MP_W-1:0]     mp9_reg;
    logic [WDAY_W-1:0]   wd9_reg;

    logic                jan_feb;
    date_t               date_next;
    date_t               date_reg;

    // Era index counted from 25 eras before the civil epoch, so it stays positive.
    assign prod_era = 49'(zz) * 49'(RECIP_ERA);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            zz4_reg <= zz;
            q4_reg  <= prod_era[SHIFT_ERA +: ERA_W];
            wd4_reg <= mod7(zz + ZZ_W'(3));
        end
    end

    assign doe_wide = zz4_reg - ZZ_W'(q4_reg) * ZZ_W'(ERA_DAYS);

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            q5_reg   <= q4_reg;
            doe5_reg <= doe_wide[DOE_W-1:0];
            wd5_reg  <= wd4_reg;
        end
    end

    // Leap-day corrections within the era.
    assign prod_1460 = 33'(doe5_reg[DOE_W-1:2]) * 33'(RECIP_365S);

    always_comb begin
        if (doe5_reg >= 18'd146096) begin
            c36524 = 18'd4;
        end else if (doe5_reg >= 18'd109572) begin
            c36524 = 18'd3;
        end else if (doe5_reg >= 18'd73048) begin
            c36524 = 18'd2;
        end else if (doe5_reg >= 18'd36524) begin
            c36524 = 18'd1;
        end else begin
            c36524 = 18'd0;
        end
        t_next = doe5_reg - DOE_W'(prod_1460[SHIFT_365S +: 7]) + c36524
                 - DOE_W'(doe5_reg == 18'd146096);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            q6_reg   <= q5_reg;
            doe6_reg <= doe5_reg;
            t6_reg   <= t_next;
            wd6_reg  <= wd5_reg;
        end
    end

    assign prod_yoe = 37'(t6_reg) * 37'(RECIP_365);

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            q7_reg   <= q6_reg;
            doe7_reg <= doe6_reg;
            yoe7_reg <= prod_yoe[SHIFT_365 +: YOE_W];
            wd7_reg  <= wd6_reg;
        end
    end

    always_comb begin
        if (yoe7_reg >= 9'd300) begin
            c100 = 18'd3;
        end else if (yoe7_reg >= 9'd200) begin
            c100 = 18'd2;
        end else if (yoe7_reg >= 9'd100) begin
            c100 = 18'd1;
        end else begin
            c100 = 18'd0;
        end
        doy_wide = doe7_reg - (DOE_W'(yoe7_reg) * DOE_W'(365)
                   + DOE_W'(yoe7_reg[YOE_W-1:2]) - c100);
        // Only used for March onward, where the calendar year is the era year.
        leap_next = (yoe7_reg[1:0] == 2'b00) && (yoe7_reg != 9'd100)
                    && (yoe7_reg != 9'd200) && (yoe7_reg != 9'd300);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            q8_reg    <= q7_reg;
            yoe8_reg  <= yoe7_reg;
            doy8_reg  <= doy_wide[YDAY_W-1:0];
            leap8_reg <= leap_next;
            wd8_reg   <= wd7_reg;
        end
    end

    assign doy_scaled = 11'(doy8_reg) * 11'(5) + 11'(2);
    assign prod_mp    = 23'(doy_scaled) * 23'(RECIP_153);

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            q9_reg    <= q8_reg;
            yoe9_reg  <= yoe8_reg;
            doy9_reg  <= doy8_reg;
            leap9_reg <= leap8_reg;
            mp9_reg   <= prod_mp[SHIFT_153 +: MP_W];
            wd9_reg   <= wd8_reg;
        end
    end

    // January and February belong to the next calendar year.
    assign jan_feb = (mp9_reg >= 4'd10);

    always_comb begin
        date_next.month_day = MDAY_W'(doy9_reg - month_start(mp9_reg) + 9'd1);
        date_next.month     = jan_feb ? (mp9_reg - 4'd10) : (mp9_reg + 4'd2);
        date_next.year_day  = jan_feb ? (doy9_reg - 9'd306)
                                      : (doy9_reg + 9'd59 + 9'(leap9_reg));
        date_next.year      = YEAR_W'(yoe9_reg) + YEAR_W'(q9_reg) * YEAR_W'(400)
                              - ERA_BIAS_YEARS + YEAR_W'(jan_feb);
        date_next.week_day  = wd9_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            date_reg <= date_next;
        end
    end

    assign date = date_reg;

endmodule

@@ hdl/datetime_to_calendar_fields.sv @@
// Throughput: one beat per cycle while m_ready lets the output move.
// There are ten register stages, each holding one item.
// An m_ready stall holds only the full stages at the output end; others still move.
// Reset (aresetn low, synchronous) clears all stage valid bits; data registers keep
// their contents. There is no configuration and no state between items.
module datetime_to_calendar_fields
    import dtc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [FUNC_W-1:0]        s_func,
    input  logic signed [DAYS_W-1:0] s_day_count,
    input  logic [TVAL_W-1:0]        s_time_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_status,
    output logic [YEAR_W-1:0]        m_year,
    output logic [MONTH_W-1:0]       m_month,
    output logic [MDAY_W-1:0]        m_month_day,
    output logic [YDAY_W-1:0]        m_year_day,
    output logic [WDAY_W-1:0]        m_week_day,
    output logic [HOUR_W-1:0]        m_hour,
    output logic [MIN_W-1:0]         m_minute,
    output logic [SEC_W-1:0]         m_second
);

    logic [NUM_STAGES-1:0] stage_en;
    logic [NUM_STAGES-1:0] bad_reg;
    logic                  bad_next;
    logic [SOD_W-1:0]      sod;
    logic [ZZ_W-1:0]       zz;
    hms_t                  hms;
    date_t                 date;
    logic                  ok;

    dtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stage_en (stage_en)
    );

    dtc_front u_front (
        .aclk         (aclk),
        .stage_en     (stage_en[FRONT_STAGES-1:0]),
        .s_func       (s_func),
        .s_day_count  (s_day_count),
        .s_time_value (s_time_value),
        .sod          (sod),
        .zz           (zz)
    );

    dtc_tod u_tod (
        .aclk     (aclk),
        .stage_en (stage_en[NUM_STAGES-1:FRONT_STAGES]),
        .sod      (sod),
        .hms      (hms)
    );

    dtc_date u_date (
        .aclk     (aclk),
        .stage_en (stage_en[NUM_STAGES-1:FRONT_STAGES]),
        .zz       (zz),
        .date     (date)
    );

    // Unsupported type selectors travel as a flag; their fields are forced to zero.
    assign bad_next = (s_func != FUNC_TICKS) && (s_func != FUNC_MINUTES);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            bad_reg[0] <= bad_next;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (stage_en[i]) begin
                bad_reg[i] <= bad_reg[i-1];
            end
        end
    end

    assign ok          = !bad_reg[NUM_STAGES-1];
    assign m_status    = bad_reg[NUM_STAGES-1];
    assign m_year      = ok ? date.year      : '0;
    assign m_month     = ok ? date.month     : '0;
    assign m_month_day = ok ? date.month_day : '0;
    assign m_year_day  = ok ? date.year_day  : '0;
    assign m_week_day  = ok ? date.week_day  : '0;
    assign m_hour      = ok ? hms.hour       : '0;
    assign m_minute    = ok ? hms.minute     : '0;
    assign m_second    = ok ? hms.second     : '0;

`ifndef NO_ASSERTIONS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_year == '0 && m_month == '0 && m_month_day == '0
            && m_year_day == '0 && m_week_day == '0 && m_hour == '0
            && m_minute == '0 && m_second == '0))
        else $error("failed beat carries nonzero fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_status) |-> (m_month <= 4'd11 && m_month_day >= 5'd1
            && m_year_day <= 9'd365 && m_week_day <= 3'd6 && m_hour <= 5'd23
            && m_minute <= 6'd59 && m_second <= 6'd59))
        else $error("calendar field out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_status && m_month == 4'd0)
            |-> (m_year_day == 9'(m_month_day) - 9'd1))
        else $error("January day of year does not match day of month");
`endif

endmodule
